/* sv/pudc_pkg.sv */
// pudc_pkg.sv: shared types and constants of the 16-to-8-bit dither quantizer
`default_nettype none

package pudc_pkg;

    // reset values of the configuration registers and the dither generator
    localparam logic [7:0]  DRIVE_RST = 8'd108;
    localparam logic [14:0] KNEE_RST  = 15'd11000;
    localparam logic [14:0] CEIL_RST  = 15'd22000;
    localparam logic [7:0]  AMP_RST   = 8'd96;
    localparam logic [31:0] RNG_SEED  = 32'h1234_5678;

    // reciprocal constants for the constant divides
    // floor(p / 100) for p < 2^23, floor(p / 255) for p <= 65025, floor(p / 3) for p < 2^17
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam int          SHIFT_100 = 30;
    localparam logic [16:0] RECIP_255 = 17'd65794;
    localparam int          SHIFT_255 = 24;
    localparam logic [16:0] RECIP_3   = 17'd87382;
    localparam int          SHIFT_3   = 18;

    localparam int N_STAGES = 6;

    typedef enum logic [1:0] {
        CFG_DRIVE = 2'd0,
        CFG_KNEE  = 2'd1,
        CFG_CEIL  = 2'd2,
        CFG_AMP   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               chunk_end;
    } t_in;

    typedef struct packed {
        logic [7:0] pcm_byte;
        logic       chunk_end_out;
    } t_out;

    typedef struct packed {
        logic [7:0]  drive;
        logic [14:0] knee;
        logic [14:0] ceil;
        logic [7:0]  amp;
    } t_cfg;

    // per-stage load strobes from the pipeline control
    typedef struct packed {
        logic [N_STAGES-1:0] adv;
    } t_pipe_ctl;

endpackage

`default_nettype wire

/* sv/pudc_dither_rng.sv */
// pudc_dither_rng.sv: xorshift32 generator giving two dither draws per sample
`default_nettype none

module pudc_dither_rng (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    output logic [7:0]      o_draw1,
    output logic [7:0]      o_draw2
);
    import pudc_pkg::*;

    logic [31:0] r_state;
    logic [31:0] w_s1;
    logic [31:0] w_s2;

    function automatic logic [31:0] f_xs(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    assign w_s1    = f_xs(r_state);
    assign w_s2    = f_xs(w_s1);
    assign o_draw1 = w_s1[7:0];
    assign o_draw2 = w_s2[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RNG_SEED;
        end else if (i_step) begin
            r_state <= w_s2;
        end
    end

endmodule

`default_nettype wire

/* sv/pudc_datapath.sv */
// pudc_datapath.sv: six-stage gain, soft-knee, dither and rounding datapath
`default_nettype none

module pudc_datapath (
    input  wire logic              i_clk,
    input  wire pudc_pkg::t_pipe_ctl i_ctl,
    input  wire pudc_pkg::t_cfg    i_cfg,
    input  wire pudc_pkg::t_in     i_in,
    input  wire logic [7:0]        i_draw1,
    input  wire logic [7:0]        i_draw2,
    output pudc_pkg::t_out         o_out
);
    import pudc_pkg::*;

    // stage 0: input register
    logic signed [15:0] r0_sample;
    logic               r0_chunk;
    logic [7:0]         r0_d1;
    logic [7:0]         r0_d2;

    // stage 1: gain and dither products
    logic               r1_neg;
    logic [22:0]        r1_prod;
    logic               r1_dneg;
    logic [15:0]        r1_dprod;
    logic               r1_chunk;

    // stage 2: quotients
    logic               r2_neg;
    logic [16:0]        r2_mag;
    logic               r2_dneg;
    logic [7:0]         r2_dq;
    logic               r2_chunk;

    // stage 3: knee excess over three
    logic               r3_neg;
    logic [16:0]        r3_mag;
    logic               r3_above;
    logic [14:0]        r3_div3;
    logic               r3_dneg;
    logic [7:0]         r3_dq;
    logic               r3_chunk;

    // stage 4: compressed magnitude
    logic               r4_neg;
    logic [14:0]        r4_magc;
    logic               r4_dneg;
    logic [7:0]         r4_dq;
    logic               r4_chunk;

    // stage 5: result register
    t_out               r5_out;

    logic signed [16:0] w_sx;
    logic [16:0]        w_mag;
    logic [24:0]        w_prod;
    logic               w_dneg;
    logic [7:0]         w_dmag;
    logic [15:0]        w_dprod;
    logic [46:0]        w_q100_full;
    logic [32:0]        w_dq_full;
    logic [16:0]        w_ex;
    logic [33:0]        w_div3_full;
    logic [15:0]        w_y;
    logic [14:0]        w_magc;
    logic signed [16:0] w_lvl;
    logic signed [16:0] w_dit;
    logic signed [16:0] w_x;
    logic signed [17:0] w_t;
    logic signed [9:0]  w_q;
    logic signed [10:0] w_b;
    logic [7:0]         w_byte;

    // stage 0 -> 1
    assign w_sx    = 17'(r0_sample);
    assign w_mag   = r0_sample[15] ? 17'(-w_sx) : 17'(w_sx);
    assign w_prod  = 25'(w_mag) * 25'(i_cfg.drive);
    assign w_dneg  = r0_d2 > r0_d1;
    assign w_dmag  = w_dneg ? (r0_d2 - r0_d1) : (r0_d1 - r0_d2);
    assign w_dprod = 16'(w_dmag) * 16'(i_cfg.amp);

    // stage 1 -> 2
    assign w_q100_full = 47'(r1_prod) * 47'(RECIP_100);
    assign w_dq_full   = 33'(r1_dprod) * 33'(RECIP_255);

    // stage 2 -> 3
    assign w_ex        = r2_mag - 17'(i_cfg.knee);
    assign w_div3_full = 34'(w_ex) * 34'(RECIP_3);

    // stage 3 -> 4: a magnitude at or below the knee is never limited
    assign w_y = 16'(i_cfg.knee) + 16'(r3_div3);
    always_comb begin
        if (r3_above) begin
            w_magc = (w_y > 16'(i_cfg.ceil)) ? i_cfg.ceil : w_y[14:0];
        end else begin
            w_magc = r3_mag[14:0];
        end
    end

    // stage 4 -> 5: add dither, round to nearest step of 256, saturate
    assign w_lvl = r4_neg  ? -$signed({2'b00, r4_magc}) : $signed({2'b00, r4_magc});
    assign w_dit = r4_dneg ? -$signed({9'd0, r4_dq})    : $signed({9'd0, r4_dq});
    assign w_x   = w_lvl + w_dit;
    assign w_t   = 18'(w_x) + 18'sd128;
    assign w_q   = 10'(w_t >>> 8);
    assign w_b   = 11'(w_q) + 11'sd128;

    always_comb begin
        priority if (w_b < 11'sd0) begin
            w_byte = 8'd0;
        end else if (w_b > 11'sd255) begin
            w_byte = 8'd255;
        end else begin
            w_byte = w_b[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r0_sample <= i_in.sample;
            r0_chunk  <= i_in.chunk_end;
            r0_d1     <= i_draw1;
            r0_d2     <= i_draw2;
        end
        if (i_ctl.adv[1]) begin
            r1_neg   <= r0_sample[15];
            r1_prod  <= w_prod[22:0];
            r1_dneg  <= w_dneg;
            r1_dprod <= w_dprod;
            r1_chunk <= r0_chunk;
        end
        if (i_ctl.adv[2]) begin
            r2_neg   <= r1_neg;
            r2_mag   <= w_q100_full[SHIFT_100 +: 17];
            r2_dneg  <= r1_dneg;
            r2_dq    <= w_dq_full[SHIFT_255 +: 8];
            r2_chunk <= r1_chunk;
        end
        if (i_ctl.adv[3]) begin
            r3_neg   <= r2_neg;
            r3_mag   <= r2_mag;
            r3_above <= r2_mag > 17'(i_cfg.knee);
            r3_div3  <= w_div3_full[SHIFT_3 +: 15];
            r3_dneg  <= r2_dneg;
            r3_dq    <= r2_dq;
            r3_chunk <= r2_chunk;
        end
        if (i_ctl.adv[4]) begin
            r4_neg   <= r3_neg;
            r4_magc  <= w_magc;
            r4_dneg  <= r3_dneg;
            r4_dq    <= r3_dq;
            r4_chunk <= r3_chunk;
        end
        if (i_ctl.adv[5]) begin
            r5_out.pcm_byte      <= w_byte;
            r5_out.chunk_end_out <= r4_chunk;
        end
    end

    assign o_out = r5_out;

endmodule

`default_nettype wire

/* sv/pcm16_to_u8_dither_compressor.sv */
// pcm16_to_u8_dither_compressor.sv: top level of the 16-to-8-bit dither quantizer
//
// Turns each signed 16-bit sample into one unsigned 8-bit PCM byte centered at 128.
// The sample is scaled by drive_percent/100, magnitudes above the knee have their
// excess cut to a third and are limited at the ceiling, triangular dither from a
// xorshift32 generator (two draws per sample, scaled by amplitude/255) is added,
// and the sum is rounded to a step of 256 and saturated to 0..255. The chunk end
// marker rides along unchanged. The block is a six-stage pipeline: one sample is
// taken every cycle while nothing stalls, and its byte passes stages 0 to 4 in
// order before it is presented from the stage 5 result register.
// Each stage holds its own valid bit and frees itself as soon as its item moves
// on, so bubbles close up and a sample is still taken while a finished byte waits
// at the output. The generator steps only on an input transfer. Configuration
// registers (0 drive, 1 knee, 2 ceiling, 3 dither amplitude) are written with
// i_cfg_we and should be changed only while the pipeline is empty.
`default_nettype none

module pcm16_to_u8_dither_compressor (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // sample input
    input  wire pudc_pkg::t_in i_in,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    // byte output
    output pudc_pkg::t_out     o_out,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    // configuration writes
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [14:0]   i_cfg_data
);
    import pudc_pkg::*;

    t_cfg                r_cfg;
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES:0]   w_rdy;
    t_pipe_ctl           w_ctl;
    logic [7:0]          w_draw1;
    logic [7:0]          w_draw2;
    logic                w_in_xfer;
    logic                w_out_xfer;

    // configuration registers, upper data bits dropped for the 8-bit ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive <= DRIVE_RST;
            r_cfg.knee  <= KNEE_RST;
            r_cfg.ceil  <= CEIL_RST;
            r_cfg.amp   <= AMP_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DRIVE: r_cfg.drive <= i_cfg_data[7:0];
                CFG_KNEE:  r_cfg.knee  <= i_cfg_data;
                CFG_CEIL:  r_cfg.ceil  <= i_cfg_data;
                CFG_AMP:   r_cfg.amp   <= i_cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    // a stage can load when it is empty or its item leaves this cycle
    always_comb begin
        w_rdy[N_STAGES] = i_out_ready;
        for (int k = N_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        for (int k = 0; k < N_STAGES; k++) begin
            if (k == 0) begin
                w_ctl.adv[k] = w_rdy[k] && i_in_valid;
            end else begin
                w_ctl.adv[k] = w_rdy[k] && r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_ctl.adv[k];
                end
            end
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[N_STAGES-1];
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_xfer  = o_out_valid && i_out_ready;

    // dither generator, two draws per accepted sample
    pudc_dither_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_in_xfer),
        .o_draw1 (w_draw1),
        .o_draw2 (w_draw2)
    );

    pudc_datapath u_dp (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_draw1 (w_draw1),
        .i_draw2 (w_draw2),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // occupancy changes only by the transfers of the previous cycle
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) == $past($countones(r_vld))
                + $past(32'(w_in_xfer)) - $past(32'(w_out_xfer))))
        else $error("pipeline occupancy mismatch");

    // a full pipeline with a stalled output takes no new sample
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_out_ready) |-> !o_in_ready)
        else $error("sample taken into a full stalled pipeline");

    // reset leaves the pipeline empty
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) && i_rst_n |-> (r_vld == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

/* tb/pudc_byte_checker.sv */
// pudc_byte_checker.sv: predicts and checks the PCM bytes of the dither quantizer
`timescale 1ns / 100ps

module pudc_byte_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pudc_pkg::t_in    i_in,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire pudc_pkg::t_out   i_out,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [14:0]      i_cfg_data,
    output int                    o_pending,
    output int                    o_fails
);
    import pudc_pkg::*;

    t_cfg        cur_cfg;
    logic [31:0] dither_state;
    logic [31:0] draw_a;
    logic [31:0] draw_b;
    t_out        expected_bytes[$];
    t_out        want;
    int          fail_count;

    initial begin
        o_pending  = 0;
        o_fails    = 0;
        fail_count = 0;
    end

    function automatic logic [31:0] xorshift_next(input logic [31:0] s);
        logic [31:0] v;
        v = s;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // gain, soft knee, ceiling, dither, rounding and clamp of one sample
    function automatic logic [7:0] quantize_sample(input logic signed [15:0] smp,
                                                   input t_cfg c,
                                                   input logic [7:0] r1,
                                                   input logic [7:0] r2);
        int mag;
        int knee_out;
        int x;
        int dmag;
        int q;
        mag = smp[15] ? (32'h10000 - int'({1'b0, smp})) : int'({1'b0, smp});
        mag = (mag * int'(c.drive)) / 100;
        if (mag > int'(c.knee)) begin
            knee_out = int'(c.knee) + (mag - int'(c.knee)) / 3;
            if (knee_out > int'(c.ceil))
                knee_out = int'(c.ceil);
            mag = knee_out;
        end
        x = smp[15] ? -mag : mag;
        dmag = (r1 >= r2) ? int'(r1) - int'(r2) : int'(r2) - int'(r1);
        dmag = (dmag * int'(c.amp)) / 255;
        x = (r2 > r1) ? x - dmag : x + dmag;
        q = ((x + 128) >>> 8) + 128;
        if (q < 0)
            q = 0;
        if (q > 255)
            q = 255;
        return 8'(q);
    endfunction

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_cfg      = '{drive: DRIVE_RST, knee: KNEE_RST, ceil: CEIL_RST, amp: AMP_RST};
            dither_state = RNG_SEED;
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DRIVE: cur_cfg.drive = i_cfg_data[7:0];
                    CFG_KNEE:  cur_cfg.knee  = i_cfg_data;
                    CFG_CEIL:  cur_cfg.ceil  = i_cfg_data;
                    CFG_AMP:   cur_cfg.amp   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // check the outgoing byte before queuing a new one
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report($sformatf("byte %0d with nothing expected", i_out.pcm_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.pcm_byte !== want.pcm_byte)
                        report($sformatf("pcm_byte expected %0d got %0d",
                                         want.pcm_byte, i_out.pcm_byte));
                    if (i_out.chunk_end_out !== want.chunk_end_out)
                        report($sformatf("chunk_end_out expected %0b got %0b",
                                         want.chunk_end_out, i_out.chunk_end_out));
                end
            end
            if (i_in_valid && i_in_ready) begin
                draw_a       = xorshift_next(dither_state);
                draw_b       = xorshift_next(draw_a);
                dither_state = draw_b;
                want.pcm_byte      = quantize_sample(i_in.sample, cur_cfg,
                                                     draw_a[7:0], draw_b[7:0]);
                want.chunk_end_out = i_in.chunk_end;
                expected_bytes.push_back(want);
            end
        end
        o_pending <= expected_bytes.size();
        o_fails   <= fail_count;
    end

endmodule

/* tb/tb.sv */
// tb.sv: stimulus and verdict for the 16-to-8-bit dither quantizer
`timescale 1ns / 100ps

module tb;
    import pudc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    t_in         i_in;
    logic        i_in_valid;
    logic        o_in_ready;
    t_out        o_out;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [14:0] i_cfg_data;

    int   pending_bytes;
    int   fail_total;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_left;
    int   cycle_count;
    logic hold_start;

    pcm16_to_u8_dither_compressor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    pudc_byte_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_out       (o_out),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending_bytes),
        .o_fails     (fail_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // byte receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_start) begin
                hold_left  = 300;
                hold_start = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // mostly full-range samples, with the rails and the area around silence favored
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return 16'($signed($urandom_range(1200)) - 600);
            default: return 16'($urandom);
        endcase
    endfunction

    // one sample transfer, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [15:0] smp, input logic ce);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in.sample    <= smp;
        i_in.chunk_end <= ce;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_sample(pick_sample(), ($urandom_range(7) == 0));
    endtask

    // stop offering and wait until every byte in flight has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [14:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // new settings once the pipeline is empty; junk above the 8-bit registers
    task automatic begin_phase(input int drive, input int knee, input int ceil,
                               input int amp, input int snd, input int rcv);
        drain();
        write_reg(CFG_DRIVE, {7'($urandom), 8'(drive)});
        write_reg(CFG_KNEE, 15'(knee));
        write_reg(CFG_CEIL, 15'(ceil));
        write_reg(CFG_AMP, {7'($urandom), 8'(amp)});
        i_cfg_we       <= 1'b0;
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in           = '0;
        i_in_valid     = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        hold_start     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: rails, silence, rounding edges, both sides of the knee
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample(16'sd127, 1'b0);
        send_sample(16'sd128, 1'b0);
        send_sample(-16'sd128, 1'b0);
        send_sample(-16'sd129, 1'b1);
        send_sample(16'sd255, 1'b0);
        send_sample(-16'sd256, 1'b0);
        send_sample(16'sd10185, 1'b0);
        send_sample(16'sd10186, 1'b0);
        send_sample(16'sd10187, 1'b1);
        send_sample(-16'sd10186, 1'b0);
        send_sample(-16'sd10187, 1'b0);
        send_sample(16'sd32000, 1'b0);
        send_sample(-16'sd32000, 1'b1);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shaaaa, 1'b0);

        // unity gain, no idling
        begin_phase(100, 11000, 22000, 96, 0, 0);
        send_random(55);

        // full gain, low knee, widest ceiling, full dither; sender idles
        begin_phase(255, 1000, 32767, 255, 65, 0);
        send_random(55);

        // ceiling below the knee, no dither; receiver stalls
        begin_phase(255, 20000, 5000, 0, 0, 65);
        send_sample(16'sd7843, 1'b0);
        send_sample(16'sd7844, 1'b0);
        send_sample(-16'sd7844, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_random(55);

        // zero gain, zero knee and ceiling: only dither is left
        begin_phase(0, 0, 0, 255, 38, 38);
        send_random(55);

        // long receiver hold-off while samples keep coming, so the pipeline backs up
        begin_phase(150, 0, 32767, 128, 0, 0);
        hold_start = 1'b1;
        send_random(40);
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        send_random(55);

        // knee at the top: plain gain into saturation
        begin_phase(255, 32767, 32767, 1, 0, 65);
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_random(55);

        // arbitrary settings
        begin_phase($urandom_range(255), $urandom_range(32767), $urandom_range(32767),
                    $urandom_range(255), 65, 0);
        send_random(55);
        begin_phase($urandom_range(255), $urandom_range(32767), $urandom_range(32767),
                    $urandom_range(255), 38, 38);
        send_random(55);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_total == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* pcm16_to_u8_dither_compressor.f */
sv/pudc_pkg.sv
sv/pudc_dither_rng.sv
sv/pudc_datapath.sv
sv/pcm16_to_u8_dither_compressor.sv
tb/pudc_byte_checker.sv
tb/tb.sv
